FILE: rtl/assert_macros.svh
// Assertion helpers, clocked on clk_i and quiet while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check in the same cycle that the antecedent holds.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check in the cycle after the antecedent holds.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ceb_pkg.sv
package ceb_pkg;

  localparam int unsigned ID_W   = 16;  // particle id
  localparam int unsigned IDX_W  = 20;  // collision index on the ports
  localparam int unsigned CNT_W  = 13;  // particle_count register
  localparam int unsigned LIM_W  = 17;  // holds any id, count or particle limit

  localparam int unsigned DEF_MAX_PARTICLES  = 4096;
  localparam int unsigned DEF_MAX_COLLISIONS = 1048576;

  localparam logic [CNT_W-1:0] PC_RESET = 13'd4096;

  // result queue entries, also the bound on words in flight
  localparam int unsigned RES_DEPTH = 4;

  typedef struct packed {
    logic [IDX_W-1:0] this_index;
    logic             prior_a_valid;
    logic [IDX_W-1:0] prior_a;
    logic             prior_b_valid;
    logic [IDX_W-1:0] prior_b;
    logic             full_res;
  } res_t;

endpackage

FILE: rtl/ceb_ram.sv
module ceb_ram #(
  parameter int unsigned WIDTH = 21,
  parameter int unsigned DEPTH = ceb_pkg::DEF_MAX_PARTICLES
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ceb_res_fifo.sv
module ceb_res_fifo #(
  parameter int unsigned DEPTH = ceb_pkg::RES_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ceb_pkg::res_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output ceb_pkg::res_t data_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ceb_pkg::res_t    mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/causal_edge_builder.sv
// Words overlap: a word may enter while the one before is in its later phases, but
//   the single read port and single write port of the particle table RAM (two reads
//   and two writes per word) keep a word out while the one before is in phase 1.
// Reset: asynchronous, active low; a clearing pass then sweeps every table entry
//   with in_ready_o low, while configuration writes are taken as usual.
`include "assert_macros.svh"

module causal_edge_builder #(
  parameter int unsigned MAX_PARTICLES  = ceb_pkg::DEF_MAX_PARTICLES,
  parameter int unsigned MAX_COLLISIONS = ceb_pkg::DEF_MAX_COLLISIONS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration: particle_count
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [ceb_pkg::CNT_W-1:0] cfg_data_i,
  // collision words
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [ceb_pkg::ID_W-1:0]  particle_a_i,
  input  logic [ceb_pkg::ID_W-1:0]  particle_b_i,
  // edge words
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [ceb_pkg::IDX_W-1:0] this_index_o,
  output logic                      prior_a_valid_o,
  output logic [ceb_pkg::IDX_W-1:0] prior_a_o,
  output logic                      prior_b_valid_o,
  output logic [ceb_pkg::IDX_W-1:0] prior_b_o,
  output logic                      full_res_o
);

  localparam int unsigned PW        = $clog2(MAX_PARTICLES);      // table address
  localparam int unsigned IW        = $clog2(MAX_COLLISIONS);     // stored index
  localparam int unsigned NW        = $clog2(MAX_COLLISIONS + 1); // index counter
  localparam int unsigned EW        = IW + 1;                     // {seen, index}
  localparam int unsigned RES_DEPTH = ceb_pkg::RES_DEPTH;
  localparam int unsigned OCC_W     = $clog2(RES_DEPTH + 1);
  localparam int unsigned LIM_W     = ceb_pkg::LIM_W;
  localparam int unsigned IDX_W     = ceb_pkg::IDX_W;

  // Per-word context carried down the pipeline.
  typedef struct packed {
    logic          a_in;    // first particle takes part (and capacity left)
    logic          b_in;    // second particle takes part and differs from first
    logic          full;
    logic [PW-1:0] a_addr;
    logic [PW-1:0] b_addr;
    logic [IW-1:0] cur;
  } item_t;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [ceb_pkg::CNT_W-1:0] pcount_q;
  logic [LIM_W-1:0]          limit;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q <= ceb_pkg::PC_RESET;
    end else if (cfg_valid_i) begin
      pcount_q <= cfg_data_i;
    end
  end

  // effective limit: the smaller of the register and the table depth
  assign limit = (LIM_W'(pcount_q) > LIM_W'(MAX_PARTICLES)) ?
                 LIM_W'(MAX_PARTICLES) : LIM_W'(pcount_q);

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  logic              clr_busy_q, clr_busy_d;
  logic [PW-1:0]     clr_addr_q, clr_addr_d;
  logic              s1_valid_q, s2_valid_q, s3_valid_q;
  logic [NW-1:0]     next_q, next_d;
  logic [OCC_W-1:0]  occ_q, occ_d;
  item_t             ctx1_q, ctx1_d;  // word in read-a / read-b phases
  item_t             ctx3_q;          // word in its result phase
  logic              in_acc, out_acc;
  logic              cap_full;

  // A word may enter when the clearing pass is over, no word entered at the
  // previous edge (a word uses the read port in both phase 1 and phase 2), and the
  // result queue is sure to have room.
  assign in_ready_o = !clr_busy_q && !s1_valid_q && (occ_q != OCC_W'(RES_DEPTH));
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_valid_o && out_ready_i;
  assign cap_full   = (next_q == NW'(MAX_COLLISIONS));

  always_comb begin
    ctx1_d        = ctx1_q;
    ctx1_d.full   = cap_full;
    ctx1_d.a_in   = !cap_full && (LIM_W'(particle_a_i) < limit);
    ctx1_d.b_in   = !cap_full && (LIM_W'(particle_b_i) < limit) &&
                    (particle_b_i != particle_a_i);
    ctx1_d.a_addr = particle_a_i[PW-1:0];
    ctx1_d.b_addr = particle_b_i[PW-1:0];
    ctx1_d.cur    = next_q[IW-1:0];
  end

  // hold the counter once capacity is used up
  assign next_d = (in_acc && !cap_full) ? next_q + NW'(1) : next_q;

  always_comb begin
    occ_d = occ_q;
    if (in_acc && !out_acc) begin
      occ_d = occ_q + OCC_W'(1);
    end else if (out_acc && !in_acc) begin
      occ_d = occ_q - OCC_W'(1);
    end
  end

  // sweep the table once after reset, one entry a cycle
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      if (clr_addr_q == PW'(MAX_PARTICLES - 1)) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      next_q     <= '0;
      occ_q      <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
      s1_valid_q <= in_acc;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      next_q     <= next_d;
      occ_q      <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ctx1_q <= ctx1_d;
    end
    if (s2_valid_q) begin
      ctx3_q <= ctx1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Particle table: {seen, last index} per particle
  //   read:  first id in phase 1, second id in phase 2
  //   write: first id in phase 2, second id in phase 3
  // ---------------------------------------------------------------------------
  logic          ram_we, ram_re;
  logic [PW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;
  logic          wr_en_q;
  logic [PW-1:0] wr_addr_q, rd_addr_q;
  logic [EW-1:0] wr_data_q;
  logic [EW-1:0] tbl_rd;
  logic [EW-1:0] rd_a_q;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr_q;
    ram_wdata = '0;
    if (clr_busy_q) begin
      ram_we = 1'b1;
    end else if (s2_valid_q) begin
      ram_we    = ctx1_q.a_in;
      ram_waddr = ctx1_q.a_addr;
      ram_wdata = {1'b1, ctx1_q.cur};
    end else if (s3_valid_q) begin
      ram_we    = ctx3_q.b_in;
      ram_waddr = ctx3_q.b_addr;
      ram_wdata = {1'b1, ctx3_q.cur};
    end
  end

  assign ram_re    = s1_valid_q || s2_valid_q;
  assign ram_raddr = s1_valid_q ? ctx1_q.a_addr : ctx1_q.b_addr;

  ceb_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_PARTICLES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Forward a write that hit the address being read in the same cycle; this
  // covers a word reading its first id while the word before records its
  // second id.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_en_q <= 1'b0;
    end else begin
      wr_en_q <= ram_we;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= ram_waddr;
    wr_data_q <= ram_wdata;
    rd_addr_q <= ram_raddr;
    if (s2_valid_q) begin
      rd_a_q <= tbl_rd;
    end
  end

  assign tbl_rd = (wr_en_q && (wr_addr_q == rd_addr_q)) ? wr_data_q : ram_rdata;

  // ---------------------------------------------------------------------------
  // Result phase: build the edge word and queue it
  // ---------------------------------------------------------------------------
  ceb_pkg::res_t res, res_head;
  logic          a_seen, b_seen;

  assign a_seen = ctx3_q.a_in && rd_a_q[IW];
  assign b_seen = ctx3_q.b_in && tbl_rd[IW];

  always_comb begin
    res               = '0;
    res.full_res      = ctx3_q.full;
    res.this_index    = ctx3_q.full ? '0 : IDX_W'(ctx3_q.cur);
    res.prior_a_valid = a_seen;
    res.prior_a       = a_seen ? IDX_W'(rd_a_q[IW-1:0]) : '0;
    res.prior_b_valid = b_seen;
    res.prior_b       = b_seen ? IDX_W'(tbl_rd[IW-1:0]) : '0;
  end

  ceb_res_fifo #(
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s3_valid_q),
    .data_i  (res),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (res_head)
  );

  assign this_index_o    = res_head.this_index;
  assign prior_a_valid_o = res_head.prior_a_valid;
  assign prior_a_o       = res_head.prior_a;
  assign prior_b_valid_o = res_head.prior_b_valid;
  assign prior_b_o       = res_head.prior_b;
  assign full_res_o      = res_head.full_res;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `ASSERT_SAME(a_one_writer, s2_valid_q, !s3_valid_q, "two table writes in one cycle")
  `ASSERT_SAME(a_next_bound, 1'b1, next_q <= NW'(MAX_COLLISIONS), "index counter overran")
  `ASSERT_SAME(a_out_counted, out_valid_o, occ_q != '0, "result shown with no word in flight")
  `ASSERT_NEXT(a_clr_quiet, clr_busy_q, !s2_valid_q && !s3_valid_q, "word moved while clearing")

endmodule
